FILE: hdl/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and round functions for the SHA-256 digest block.
// ----------------------------------------------------------------------------
package sha_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       end_of_message;
   } sha_req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic        final_word;
   } sha_rsp_type;

   // sequencer to datapath controls
   typedef struct packed {
      logic       push;
      logic [7:0] push_byte;
      logic       load;
      logic       round;
      logic [5:0] round_idx;
      logic       fold;
      logic       init;
   } sha_ctl_type;

   localparam int BLOCK_BYTES = 512 / 8;
   localparam int LEN_POS     = 448 / 8;

   localparam logic [5:0] POS_LAST = 6'(BLOCK_BYTES - 1);
   localparam logic [5:0] POS_LEN  = 6'(LEN_POS);
   localparam logic [7:0] PAD_BYTE = 8'h80;

   localparam logic [31:0] IV [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] bsig0(input logic [31:0] x);
      bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic logic [31:0] bsig1(input logic [31:0] x);
      bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic logic [31:0] ssig0(input logic [31:0] x);
      ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] ssig1(input logic [31:0] x);
      ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   function automatic logic [31:0] round_k(input logic [5:0] r);
      case (r)
         6'd0:  round_k = 32'h428a2f98;
         6'd1:  round_k = 32'h71374491;
         6'd2:  round_k = 32'hb5c0fbcf;
         6'd3:  round_k = 32'he9b5dba5;
         6'd4:  round_k = 32'h3956c25b;
         6'd5:  round_k = 32'h59f111f1;
         6'd6:  round_k = 32'h923f82a4;
         6'd7:  round_k = 32'hab1c5ed5;
         6'd8:  round_k = 32'hd807aa98;
         6'd9:  round_k = 32'h12835b01;
         6'd10: round_k = 32'h243185be;
         6'd11: round_k = 32'h550c7dc3;
         6'd12: round_k = 32'h72be5d74;
         6'd13: round_k = 32'h80deb1fe;
         6'd14: round_k = 32'h9bdc06a7;
         6'd15: round_k = 32'hc19bf174;
         6'd16: round_k = 32'he49b69c1;
         6'd17: round_k = 32'hefbe4786;
         6'd18: round_k = 32'h0fc19dc6;
         6'd19: round_k = 32'h240ca1cc;
         6'd20: round_k = 32'h2de92c6f;
         6'd21: round_k = 32'h4a7484aa;
         6'd22: round_k = 32'h5cb0a9dc;
         6'd23: round_k = 32'h76f988da;
         6'd24: round_k = 32'h983e5152;
         6'd25: round_k = 32'ha831c66d;
         6'd26: round_k = 32'hb00327c8;
         6'd27: round_k = 32'hbf597fc7;
         6'd28: round_k = 32'hc6e00bf3;
         6'd29: round_k = 32'hd5a79147;
         6'd30: round_k = 32'h06ca6351;
         6'd31: round_k = 32'h14292967;
         6'd32: round_k = 32'h27b70a85;
         6'd33: round_k = 32'h2e1b2138;
         6'd34: round_k = 32'h4d2c6dfc;
         6'd35: round_k = 32'h53380d13;
         6'd36: round_k = 32'h650a7354;
         6'd37: round_k = 32'h766a0abb;
         6'd38: round_k = 32'h81c2c92e;
         6'd39: round_k = 32'h92722c85;
         6'd40: round_k = 32'ha2bfe8a1;
         6'd41: round_k = 32'ha81a664b;
         6'd42: round_k = 32'hc24b8b70;
         6'd43: round_k = 32'hc76c51a3;
         6'd44: round_k = 32'hd192e819;
         6'd45: round_k = 32'hd6990624;
         6'd46: round_k = 32'hf40e3585;
         6'd47: round_k = 32'h106aa070;
         6'd48: round_k = 32'h19a4c116;
         6'd49: round_k = 32'h1e376c08;
         6'd50: round_k = 32'h2748774c;
         6'd51: round_k = 32'h34b0bcb5;
         6'd52: round_k = 32'h391c0cb3;
         6'd53: round_k = 32'h4ed8aa4a;
         6'd54: round_k = 32'h5b9cca4f;
         6'd55: round_k = 32'h682e6ff3;
         6'd56: round_k = 32'h748f82ee;
         6'd57: round_k = 32'h78a5636f;
         6'd58: round_k = 32'h84c87814;
         6'd59: round_k = 32'h8cc70208;
         6'd60: round_k = 32'h90befffa;
         6'd61: round_k = 32'ha4506ceb;
         6'd62: round_k = 32'hbef9a3f7;
         6'd63: round_k = 32'hc67178f2;
         default: round_k = 32'h0;
      endcase
   endfunction

endpackage

FILE: hdl/sha_sched.sv
// ----------------------------------------------------------------------------
// sha_sched
// Block buffer and rolling message schedule: bytes shift in, words shift out.
// ----------------------------------------------------------------------------
module sha_sched (
   input  logic                clock,
   input  sha_pkg::sha_ctl_type ctl,
   output logic [31:0]         w_cur
);
   import sha_pkg::*;

   logic [511:0] win_ff;
   logic [511:0] win_in;
   logic [31:0]  w_new;

   // word i sits at win_ff[511-32*i -: 32]
   assign w_new = ssig1(win_ff[63:32]) + win_ff[223:192] + ssig0(win_ff[479:448])
                + win_ff[511:480];
   assign w_cur = win_ff[511:480];

   always_comb begin
      win_in = win_ff;
      if (ctl.push) begin
         win_in = {win_ff[503:0], ctl.push_byte};
      end else if (ctl.round) begin
         win_in = {win_ff[479:0], w_new};
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

endmodule

FILE: hdl/sha_core.sv
// ----------------------------------------------------------------------------
// sha_core
// Compression unit: one round per cycle on a..h, chaining value fold.
// ----------------------------------------------------------------------------
module sha_core (
   input  logic                clock,
   input  logic                reset,
   input  sha_pkg::sha_ctl_type ctl,
   input  logic [31:0]         w_cur,
   input  logic [2:0]          digest_sel,
   output logic [31:0]         digest
);
   import sha_pkg::*;

   logic [31:0] chain_ff [8];
   logic [31:0] chain_in [8];
   logic [31:0] var_ff   [8];
   logic [31:0] var_in   [8];
   logic [31:0] t1;
   logic [31:0] t2;

   assign t1 = var_ff[7] + bsig1(var_ff[4])
             + ((var_ff[4] & var_ff[5]) ^ (~var_ff[4] & var_ff[6]))
             + round_k(ctl.round_idx) + w_cur;
   assign t2 = bsig0(var_ff[0])
             + ((var_ff[0] & var_ff[1]) ^ (var_ff[0] & var_ff[2]) ^ (var_ff[1] & var_ff[2]));

   assign digest = chain_ff[digest_sel];

   always_comb begin
      for (int j = 0; j < 8; j++) begin
         var_in[j]   = var_ff[j];
         chain_in[j] = chain_ff[j];
      end
      if (ctl.load) begin
         for (int j = 0; j < 8; j++) begin
            var_in[j] = chain_ff[j];
         end
      end else if (ctl.round) begin
         var_in[7] = var_ff[6];
         var_in[6] = var_ff[5];
         var_in[5] = var_ff[4];
         var_in[4] = var_ff[3] + t1;
         var_in[3] = var_ff[2];
         var_in[2] = var_ff[1];
         var_in[1] = var_ff[0];
         var_in[0] = t1 + t2;
      end
      if (ctl.init) begin
         for (int j = 0; j < 8; j++) begin
            chain_in[j] = IV[j];
         end
      end else if (ctl.fold) begin
         for (int j = 0; j < 8; j++) begin
            chain_in[j] = chain_ff[j] + var_ff[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < 8; j++) begin
         var_ff[j] <= var_in[j];
      end
      if (reset) begin
         for (int j = 0; j < 8; j++) begin
            chain_ff[j] <= IV[j];
         end
      end else begin
         for (int j = 0; j < 8; j++) begin
            chain_ff[j] <= chain_in[j];
         end
      end
   end

endmodule

FILE: hdl/sha256_message_digest.sv
// ----------------------------------------------------------------------------
// sha256_message_digest
// SHA-256 over a byte stream; emits eight digest words per message.
// ----------------------------------------------------------------------------
//   channel   direction   payload
//   req_      in          data_byte, byte_present, end_of_message
//   rsp_      out         digest_word, final_word (set on H7)
//
// The 64th byte of a block starts a compression (load, 64 rounds on the
// shared round unit, fold). The end of a message pads one byte a cycle
// up to the block end (into a second block when the length does not fit),
// compresses, then shows 8 words.
// req_ready is low while the sequencer is busy; rsp_ready low holds a word.
// Reset is synchronous; no clearing pass.
// ----------------------------------------------------------------------------
module sha256_message_digest (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  sha_pkg::sha_req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output sha_pkg::sha_rsp_type rsp_data
);
   import sha_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_PAD  = 3'd1;
   localparam logic [2:0] ST_LOAD = 3'd2;
   localparam logic [2:0] ST_RND  = 3'd3;
   localparam logic [2:0] ST_FOLD = 3'd4;
   localparam logic [2:0] ST_OUT  = 3'd5;

   logic [2:0]  state_ff,  state_in;
   logic [5:0]  pos_ff,    pos_in;
   logic [60:0] count_ff,  count_in;
   logic [63:0] len_ff,    len_in;
   logic [5:0]  rnd_ff,    rnd_in;
   logic [2:0]  idx_ff,    idx_in;
   logic        end_ff,    end_in;
   logic        fin_ff,    fin_in;
   logic        sent80_ff, sent80_in;
   logic        lenph_ff,  lenph_in;
   logic        rspv_ff,   rspv_in;

   sha_ctl_type ctl;
   logic        accept;
   logic [60:0] count_nx;
   logic [31:0] w_cur;
   logic [31:0] digest;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign count_nx  = req_data.byte_present ? count_ff + 61'd1 : count_ff;

   assign rsp_valid            = rspv_ff;
   assign rsp_data.digest_word = digest;
   assign rsp_data.final_word  = (idx_ff == 3'd7);

   always_comb begin
      state_in  = state_ff;
      pos_in    = pos_ff;
      count_in  = count_ff;
      len_in    = len_ff;
      rnd_in    = rnd_ff;
      idx_in    = idx_ff;
      end_in    = end_ff;
      fin_in    = fin_ff;
      sent80_in = sent80_ff;
      lenph_in  = lenph_ff;
      rspv_in   = rspv_ff;
      ctl       = '0;
      ctl.round_idx = rnd_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.byte_present) begin
                  ctl.push      = 1'b1;
                  ctl.push_byte = req_data.data_byte;
                  pos_in        = pos_ff + 6'd1;
                  count_in      = count_nx;
               end
               if (req_data.end_of_message) begin
                  end_in = 1'b1;
                  len_in = {count_nx, 3'b000};
               end
               if (req_data.byte_present && pos_ff == POS_LAST) begin
                  state_in = ST_LOAD;
               end else if (req_data.end_of_message) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            ctl.push = 1'b1;
            pos_in   = pos_ff + 6'd1;
            if (!sent80_ff) begin
               ctl.push_byte = PAD_BYTE;
               sent80_in     = 1'b1;
            end else if (lenph_ff || pos_ff == POS_LEN) begin
               ctl.push_byte = len_ff[63:56];
               len_in        = {len_ff[55:0], 8'h00};
               lenph_in      = 1'b1;
               if (pos_ff == POS_LAST) begin
                  fin_in = 1'b1;
               end
            end else begin
               ctl.push_byte = 8'h00;
            end
            if (pos_ff == POS_LAST) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            ctl.load = 1'b1;
            rnd_in   = 6'd0;
            state_in = ST_RND;
         end
         ST_RND: begin
            ctl.round = 1'b1;
            rnd_in    = rnd_ff + 6'd1;
            if (rnd_ff == POS_LAST) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            ctl.fold = 1'b1;
            if (fin_ff) begin
               state_in = ST_OUT;
               rspv_in  = 1'b1;
               idx_in   = 3'd0;
            end else if (end_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUT: begin
            if (rspv_ff && rsp_ready) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  rspv_in   = 1'b0;
                  state_in  = ST_IDLE;
                  ctl.init  = 1'b1;
                  count_in  = '0;
                  pos_in    = '0;
                  end_in    = 1'b0;
                  fin_in    = 1'b0;
                  sent80_in = 1'b0;
                  lenph_in  = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         pos_ff    <= '0;
         count_ff  <= '0;
         rnd_ff    <= '0;
         idx_ff    <= '0;
         end_ff    <= 1'b0;
         fin_ff    <= 1'b0;
         sent80_ff <= 1'b0;
         lenph_ff  <= 1'b0;
         rspv_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         pos_ff    <= pos_in;
         count_ff  <= count_in;
         rnd_ff    <= rnd_in;
         idx_ff    <= idx_in;
         end_ff    <= end_in;
         fin_ff    <= fin_in;
         sent80_ff <= sent80_in;
         lenph_ff  <= lenph_in;
         rspv_ff   <= rspv_in;
      end
      len_ff <= len_in;
   end

   sha_sched u_sched (
      .clock (clock),
      .ctl   (ctl),
      .w_cur (w_cur)
   );

   sha_core u_core (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .w_cur      (w_cur),
      .digest_sel (idx_ff),
      .digest     (digest)
   );

endmodule

FILE: tb/sha256_message_digest_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sha256_message_digest_check
// Watches both channels of the digest block, hashes every accepted request
// on its own copy of the SHA-256 state and compares each digest word that
// leaves the block, in order, with the words it has worked out.
// ----------------------------------------------------------------------------
module sha256_message_digest_check (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  sha_pkg::sha_req_type req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  sha_pkg::sha_rsp_type rsp_data,
   output int                   fail_count,
   output int                   words_pending,
   output int                   words_checked
);

   localparam logic [31:0] ROUND_CONST [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   logic [31:0] chain_h [8];
   logic [31:0] sched [16];
   logic [60:0] byte_count;
   sha_pkg::sha_rsp_type digest_words [$];
   int mismatches = 0;
   int checked = 0;
   int pending = 0;

   assign fail_count    = mismatches;
   assign words_checked = checked;
   assign words_pending = pending;

   function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
      logic [63:0] d;
      d = {x, x} >> n;
      return d[31:0];
   endfunction

   task automatic put_byte(input int pos, input logic [7:0] b);
      int idx;
      int sh;
      idx = (pos >> 2) & 15;
      sh  = (3 - (pos & 3)) * 8;
      sched[idx] = (sched[idx] & ~(32'hff << sh)) | (32'(b) << sh);
   endtask

   task automatic compress_block();
      logic [31:0] v [8];
      logic [31:0] w2, w7, w15, t1, t2;
      int r, j;
      for (j = 0; j < 8; j++) v[j] = chain_h[j];
      for (r = 0; r < 64; r++) begin
         if (r >= 16) begin
            w2  = sched[(r - 2) & 15];
            w7  = sched[(r - 7) & 15];
            w15 = sched[(r - 15) & 15];
            sched[r & 15] = (ror32(w2, 17) ^ ror32(w2, 19) ^ (w2 >> 10)) + w7
                          + (ror32(w15, 7) ^ ror32(w15, 18) ^ (w15 >> 3))
                          + sched[r & 15];
         end
         t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[r] + sched[r & 15];
         t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         for (j = 7; j > 0; j--) v[j] = v[j - 1];
         v[4] = v[4] + t1;
         v[0] = t1 + t2;
      end
      for (j = 0; j < 8; j++) chain_h[j] = chain_h[j] + v[j];
   endtask

   task automatic absorb_request(input sha_pkg::sha_req_type r);
      int pos, p, j;
      logic [63:0] bit_len;
      sha_pkg::sha_rsp_type w;
      if (r.byte_present) begin
         pos = int'(byte_count[5:0]);
         put_byte(pos, r.data_byte);
         byte_count = byte_count + 61'd1;
         if (pos == 63) compress_block();
      end
      if (r.end_of_message) begin
         pos = int'(byte_count[5:0]);
         put_byte(pos, sha_pkg::PAD_BYTE);
         for (p = pos + 1; p < 64; p++) put_byte(p, 8'h00);
         // no room for the length field: close this block, start a zero one
         if (pos >= sha_pkg::LEN_POS) begin
            compress_block();
            for (j = 0; j < 16; j++) sched[j] = '0;
         end
         bit_len   = {byte_count, 3'b000};
         sched[14] = bit_len[63:32];
         sched[15] = bit_len[31:0];
         compress_block();
         for (j = 0; j < 8; j++) begin
            w.digest_word = chain_h[j];
            w.final_word  = (j == 7);
            digest_words.push_back(w);
         end
         for (j = 0; j < 8; j++) chain_h[j] = sha_pkg::IV[j];
         byte_count = '0;
      end
   endtask

   always @(posedge clock) begin
      sha_pkg::sha_rsp_type exp_word;
      int j;
      if (reset) begin
         for (j = 0; j < 8; j++) chain_h[j] = sha_pkg::IV[j];
         for (j = 0; j < 16; j++) sched[j] = '0;
         byte_count = '0;
         digest_words.delete();
      end else begin
         if (req_valid && req_ready) absorb_request(req_data);
         if (rsp_valid && rsp_ready) begin
            if (digest_words.size() == 0) begin
               $error("digest word %h with no request outstanding", rsp_data.digest_word);
               mismatches++;
            end else begin
               exp_word = digest_words.pop_front();
               checked++;
               if (rsp_data.digest_word !== exp_word.digest_word) begin
                  $error("digest_word: expected %h, actual %h",
                         exp_word.digest_word, rsp_data.digest_word);
                  mismatches++;
               end
               if (rsp_data.final_word !== exp_word.final_word) begin
                  $error("final_word: expected %b, actual %b",
                         exp_word.final_word, rsp_data.final_word);
                  mismatches++;
               end
            end
         end
      end
      pending <= digest_words.size();
   end

endmodule

FILE: tb/sha256_message_digest_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sha256_message_digest_test
// Feeds byte messages of many lengths to the digest block: a few fixed
// cases first, then random messages under three mixes of input and output
// stalls, with one long output hold-off that backs up the input. The
// checker beside the block predicts and compares every digest word.
// ----------------------------------------------------------------------------
module sha256_message_digest_test;

   localparam int CYCLE_LIMIT     = 1000000;
   localparam int RSP_HOLD_CYCLES = 600;
   localparam int DRAIN_CYCLES    = 140;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic rsp_ready = 1'b0;
   logic rsp_hold  = 1'b0;
   sha_pkg::sha_req_type req_data = '0;
   logic req_ready;
   logic rsp_valid;
   sha_pkg::sha_rsp_type rsp_data;

   int fail_count;
   int words_pending;
   int words_checked;
   int recv_idle = 65;
   int send_idle = 22;
   int items_sent = 0;
   int bytes_sent = 0;
   int messages_sent = 0;
   int cycle_count = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   sha256_message_digest i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   sha256_message_digest_check i_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .words_pending (words_pending),
      .words_checked (words_checked)
   );

   function automatic sha_pkg::sha_req_type make_req(input logic [7:0] b, input logic present,
                                                     input logic eom);
      sha_pkg::sha_req_type r;
      r.data_byte      = b;
      r.byte_present   = present;
      r.end_of_message = eom;
      return r;
   endfunction

   // returns at the edge where the request is accepted, valid still high
   task automatic send_item(input sha_pkg::sha_req_type r);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      if (r.byte_present || r.end_of_message) items_sent++;
      if (r.byte_present) bytes_sent++;
      if (r.end_of_message) messages_sent++;
   endtask

   task automatic send_message(input int len, input bit split_end);
      int n;
      for (n = 0; n < len; n++) begin
         if ($urandom_range(99) < 8) send_item(make_req(8'($urandom), 1'b0, 1'b0));
         send_item(make_req(8'($urandom), 1'b1, (n == len - 1) && !split_end));
      end
      if (len == 0 || split_end) send_item(make_req(8'($urandom), 1'b0, 1'b1));
   endtask

   function automatic int pick_length();
      int boundary_lens [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
      int sel;
      sel = $urandom_range(9);
      if (sel <= 5) return $urandom_range(20);
      if (sel <= 8) return boundary_lens[$urandom_range(9)];
      return $urandom_range(130);
   endfunction

   task automatic wait_for_digests();
      req_valid <= 1'b0;
      do @(posedge clock); while (words_pending != 0);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_item(make_req(8'hff, 1'b0, 1'b0));
      send_item(make_req(8'h5a, 1'b0, 1'b1));
      send_item(make_req(8'h00, 1'b1, 1'b1));
      send_item(make_req(8'hff, 1'b1, 1'b1));
      send_item(make_req(8'h61, 1'b1, 1'b0));
      send_item(make_req(8'h62, 1'b1, 1'b0));
      send_item(make_req(8'h63, 1'b1, 1'b1));
      send_item(make_req(8'h61, 1'b1, 1'b0));
      send_item(make_req(8'h62, 1'b1, 1'b0));
      send_item(make_req(8'h63, 1'b1, 1'b0));
      send_item(make_req(8'hff, 1'b0, 1'b1));
      send_item(make_req(8'h00, 1'b0, 1'b0));
      send_item(make_req(8'h80, 1'b1, 1'b1));

      while (items_sent < 110) send_message(pick_length(), 1'($urandom_range(1)));
      wait_for_digests();

      send_idle = 65;
      recv_idle <= 22;
      while (items_sent < 220) send_message(pick_length(), 1'($urandom_range(1)));
      wait_for_digests();

      // no idling; output held off long enough to back up the input
      send_idle = 0;
      recv_idle <= 0;
      rsp_hold  <= 1'b1;
      while (items_sent < 330) send_message(pick_length(), 1'($urandom_range(1)));
      wait_for_digests();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d messages, %0d bytes in %0d requests; %0d digest words checked",
               messages_sent, bytes_sent, items_sent, words_checked);
      $display("with input and output stalls both ways and a %0d-cycle output hold-off",
               RSP_HOLD_CYCLES);
      if (fail_count == 0 && words_pending == 0) begin
         $display("sha256_message_digest: match");
      end else begin
         $display("sha256_message_digest: mismatch");
      end
      $finish;
   end

   initial begin
      bit hold_done;
      int k;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold && !hold_done) begin
            hold_done = 1'b1;
            for (k = 0; k < RSP_HOLD_CYCLES; k++) begin
               rsp_ready <= 1'b0;
               @(posedge clock);
            end
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle);
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", cycle_count);
      $display("sha256_message_digest: mismatch");
      $finish;
   end

endmodule
